FILE: sv/slx_pkg.sv
package slx_pkg;

   localparam int unsigned MAX_PROGRAM_BYTES = 65536;
   localparam int unsigned IN_QUEUE_DEPTH    = 2;
   localparam int unsigned OUT_QUEUE_DEPTH   = 4;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   typedef enum logic [3:0] {
      CLS_LPAREN = 4'd0,
      CLS_RPAREN = 4'd1,
      CLS_QUOTE  = 4'd2,
      CLS_MINUS  = 4'd3,
      CLS_SPACE  = 4'd4,
      CLS_DOT    = 4'd5,
      CLS_DIGIT  = 4'd6,
      CLS_ALPHA  = 4'd7,
      CLS_OTHER  = 4'd8
   } cls_type;

   typedef enum logic [3:0] {
      KIND_LPAREN  = 4'd0,
      KIND_RPAREN  = 4'd1,
      KIND_MINUS   = 4'd2,
      KIND_INTEGER = 4'd3,
      KIND_DECIMAL = 4'd4,
      KIND_STRING  = 4'd5,
      KIND_IDENT   = 4'd6,
      KIND_BADCHAR = 4'd7,
      KIND_UNTERM  = 4'd8
   } kind_type;

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_MINUS   = 6'b000010,
      MODE_NUMBER  = 6'b000100,
      MODE_DECIMAL = 6'b001000,
      MODE_STRING  = 6'b010000,
      MODE_IDENT   = 6'b100000
   } mode_type;

   typedef struct packed {
      cls_type     cls;
      logic [15:0] position;
      logic        eop;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } result_type;

   function automatic cls_type classify(input logic [7:0] c);
      cls_type cls;
      if (c == CH_LPAREN)                       cls = CLS_LPAREN;
      else if (c == CH_RPAREN)                  cls = CLS_RPAREN;
      else if (c == CH_QUOTE)                   cls = CLS_QUOTE;
      else if (c == CH_MINUS)                   cls = CLS_MINUS;
      else if (c == CH_SPACE)                   cls = CLS_SPACE;
      else if (c == CH_DOT)                     cls = CLS_DOT;
      else if (c >= 8'h30 && c <= 8'h39)        cls = CLS_DIGIT;
      else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER)
         cls = CLS_ALPHA;
      else                                      cls = CLS_OTHER;
      return cls;
   endfunction

   function automatic logic [16:0] span(input logic [16:0] from_pos, input logic [16:0] to_pos);
      return (to_pos > from_pos) ? to_pos - from_pos : 17'd0;
   endfunction

   function automatic logic [15:0] sat16(input logic [16:0] v);
      return v[16] ? 16'hFFFF : v[15:0];
   endfunction

   function automatic result_type make_result(input kind_type k, input logic [16:0] st,
                                              input logic [16:0] len);
      result_type r;
      r.kind   = k;
      r.start  = sat16(st);
      r.length = sat16(len);
      r.last   = 1'b0;
      return r;
   endfunction

endpackage

FILE: sv/slx_if.sv
interface slx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_program;

   modport source (output valid, output char_code, output end_of_program, input ready);
   modport sink   (input valid, input char_code, input end_of_program, output ready);
endinterface

interface slx_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic        last_of_program;

   modport source (output valid, output token_kind, output token_start, output token_length,
                   output last_of_program, input ready);
   modport sink   (input valid, input token_kind, input token_start, input token_length,
                   input last_of_program, output ready);
endinterface

FILE: sv/script_token_lexer_core.sv
// Streaming tokenizer: takes one byte of program text per transaction and returns
// tokens as kind, start offset and length, with last_of_program on the final token.
// A byte is accepted every cycle while the result side keeps up; a byte that closes
// one token and opens a single-byte one (or an integer followed by a stray point)
// yields two results, which the 4-entry result queue drains at one per cycle while
// the receiver is ready. A byte passes through a 2-entry queue after classification,
// and its results are written into the result queue before the first is offered.
// After an error result all bytes up to and including the final one are swallowed
// silently.
module script_token_lexer_core #(
   parameter int unsigned MAX_PROGRAM_BYTES = slx_pkg::MAX_PROGRAM_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   slx_req_if.sink   req_if,
   slx_rsp_if.source rsp_if
);
   localparam int unsigned IN_DEPTH  = slx_pkg::IN_QUEUE_DEPTH;
   localparam int unsigned OUT_DEPTH = slx_pkg::OUT_QUEUE_DEPTH;
   localparam int unsigned IN_CW     = $clog2(IN_DEPTH + 1);
   localparam int unsigned OUT_CW    = $clog2(OUT_DEPTH + 1);
   localparam int unsigned ITEM_W    = $bits(slx_pkg::item_type);
   localparam int unsigned RES_W     = $bits(slx_pkg::result_type);

   logic                front_push;
   slx_pkg::item_type   front_item;
   logic [ITEM_W-1:0]   in_push_data [2];
   logic [ITEM_W-1:0]   in_head;
   logic [IN_CW-1:0]    in_count;
   logic                in_pop;

   logic [1:0]          res_push_count;
   slx_pkg::result_type res_items [2];
   logic [RES_W-1:0]    out_push_data [2];
   logic [RES_W-1:0]    out_head;
   logic [OUT_CW-1:0]   out_count;
   logic                out_pop;
   slx_pkg::result_type head_res;

   slx_front #(
      .MAX_PROGRAM_BYTES (MAX_PROGRAM_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_room (in_count < IN_CW'(IN_DEPTH)),
      .push       (front_push),
      .item       (front_item)
   );

   assign in_push_data[0] = front_item;
   assign in_push_data[1] = front_item;

   slx_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (IN_DEPTH)
   ) u_in_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count ({1'b0, front_push}),
      .push_data  (in_push_data),
      .pop        (in_pop),
      .pop_data   (in_head),
      .count      (in_count)
   );

   // back end needs room for two results before it takes a byte
   slx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_count != '0),
      .item       (slx_pkg::item_type'(in_head)),
      .out_room   (out_count <= OUT_CW'(OUT_DEPTH - 2)),
      .item_pop   (in_pop),
      .push_count (res_push_count),
      .results    (res_items)
   );

   assign out_push_data[0] = res_items[0];
   assign out_push_data[1] = res_items[1];

   slx_fifo #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_push_count),
      .push_data  (out_push_data),
      .pop        (out_pop),
      .pop_data   (out_head),
      .count      (out_count)
   );

   assign head_res               = slx_pkg::result_type'(out_head);
   assign rsp_if.valid           = (out_count != '0);
   assign out_pop                = rsp_if.valid & rsp_if.ready;
   assign rsp_if.token_kind      = head_res.kind;
   assign rsp_if.token_start     = head_res.start;
   assign rsp_if.token_length    = head_res.length;
   assign rsp_if.last_of_program = head_res.last;

endmodule

FILE: sv/slx_fifo.sv
module slx_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   push_count,
   input  logic [WIDTH-1:0]             push_data [2],
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   // DEPTH is a power of two; pointers wrap naturally.
   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [PW-1:0]    wr_next;

   assign wr_next   = wr_ptr_ff + PW'(1);
   assign wr_ptr_in = wr_ptr_ff + PW'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + CW'(push_count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push_data[1];
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

FILE: sv/slx_front.sv
module slx_front #(
   parameter int unsigned MAX_PROGRAM_BYTES = slx_pkg::MAX_PROGRAM_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   slx_req_if.sink           req_if,
   input  logic              queue_room,
   output logic              push,
   output slx_pkg::item_type item
);
   localparam int unsigned POS_LIMIT =
      (MAX_PROGRAM_BYTES - 1 > 65535) ? 65535 : MAX_PROGRAM_BYTES - 1;
   localparam logic [15:0] POS_MAX = 16'(POS_LIMIT);

   logic [15:0] pos_ff, pos_in;

   assign req_if.ready = queue_room;
   assign push         = req_if.valid & queue_room;

   assign item.cls      = slx_pkg::classify(req_if.char_code);
   assign item.position = pos_ff;
   assign item.eop      = req_if.end_of_program;

   // position restarts after the final byte, sticks at the limit on long programs
   always_comb begin
      pos_in = pos_ff;
      if (push) begin
         if (req_if.end_of_program)  pos_in = '0;
         else if (pos_ff < POS_MAX)  pos_in = pos_ff + 16'd1;
         else                        pos_in = POS_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: sv/slx_back.sv
module slx_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  slx_pkg::item_type   item,
   input  logic                out_room,
   output logic                item_pop,
   output logic [1:0]          push_count,
   output slx_pkg::result_type results [2]
);
   slx_pkg::mode_type mode_ff, mode_in;
   logic [15:0]       ls_ff, ls_in;
   logic              pp_ff, pp_in;
   logic              err_ff, err_in;

   slx_pkg::result_type res_v [2];
   logic [1:0]          n_v;
   logic                taken;
   logic                failed;
   logic [16:0]         p17;
   logic [16:0]         dot17;
   logic [16:0]         end17;
   logic                is_digit;

   assign item_pop = item_valid & out_room;
   assign p17      = {1'b0, item.position};
   assign end17    = p17 + 17'd1;
   assign dot17    = (p17 != 17'd0) ? p17 - 17'd1 : 17'd0;
   assign is_digit = (item.cls == slx_pkg::CLS_DIGIT);

   always_comb begin
      mode_in = mode_ff;
      ls_in   = ls_ff;
      pp_in   = pp_ff;
      err_in  = err_ff;
      res_v[0] = '0;
      res_v[1] = '0;
      n_v     = 2'd0;
      taken   = 1'b0;
      failed  = 1'b0;

      if (err_ff) begin
         // discard until the final byte
         if (item.eop) begin
            mode_in = slx_pkg::MODE_IDLE;
            ls_in   = '0;
            pp_in   = 1'b0;
            err_in  = 1'b0;
         end
      end else begin
         case (mode_ff)
            slx_pkg::MODE_MINUS: begin
               if (is_digit) begin
                  mode_in = slx_pkg::MODE_NUMBER;
                  taken   = 1'b1;
               end else begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_MINUS,
                                                       {1'b0, ls_in}, 17'd1);
                  n_v = n_v + 2'd1;
                  mode_in = slx_pkg::MODE_IDLE;
               end
            end
            slx_pkg::MODE_NUMBER: begin
               if (is_digit) begin
                  if (pp_in) begin
                     pp_in   = 1'b0;
                     mode_in = slx_pkg::MODE_DECIMAL;
                  end
                  taken = 1'b1;
               end else if (pp_in) begin
                  // point with no digit after it: integer, then the point is a bad char
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_INTEGER, {1'b0, ls_in},
                                     slx_pkg::span({1'b0, ls_in}, dot17));
                  n_v = n_v + 2'd1;
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_BADCHAR, dot17, 17'd1);
                  res_v[n_v[0]].last = 1'b1;
                  n_v = n_v + 2'd1;
                  failed  = 1'b1;
                  mode_in = slx_pkg::MODE_IDLE;
                  pp_in   = 1'b0;
                  taken   = 1'b1;
               end else if (item.cls == slx_pkg::CLS_DOT) begin
                  pp_in = 1'b1;
                  taken = 1'b1;
               end else begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_INTEGER, {1'b0, ls_in},
                                     slx_pkg::span({1'b0, ls_in}, p17));
                  n_v = n_v + 2'd1;
                  mode_in = slx_pkg::MODE_IDLE;
               end
            end
            slx_pkg::MODE_DECIMAL: begin
               if (is_digit) begin
                  taken = 1'b1;
               end else begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_DECIMAL, {1'b0, ls_in},
                                     slx_pkg::span({1'b0, ls_in}, p17));
                  n_v = n_v + 2'd1;
                  mode_in = slx_pkg::MODE_IDLE;
               end
            end
            slx_pkg::MODE_STRING: begin
               if (item.cls == slx_pkg::CLS_QUOTE) begin
                  // offsets exclude the quotes
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_STRING,
                                     {1'b0, ls_in} + 17'd1,
                                     slx_pkg::span({1'b0, ls_in} + 17'd1, p17));
                  n_v = n_v + 2'd1;
                  mode_in = slx_pkg::MODE_IDLE;
               end
               taken = 1'b1;
            end
            slx_pkg::MODE_IDENT: begin
               if (is_digit || item.cls == slx_pkg::CLS_ALPHA) begin
                  taken = 1'b1;
               end else begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_IDENT, {1'b0, ls_in},
                                     slx_pkg::span({1'b0, ls_in}, p17));
                  n_v = n_v + 2'd1;
                  mode_in = slx_pkg::MODE_IDLE;
               end
            end
            default: begin
               mode_in = slx_pkg::MODE_IDLE;
            end
         endcase

         if (!taken && !failed) begin
            ls_in = item.position;
            pp_in = 1'b0;
            case (item.cls)
               slx_pkg::CLS_LPAREN: begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_LPAREN, p17, 17'd1);
                  n_v = n_v + 2'd1;
               end
               slx_pkg::CLS_RPAREN: begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_RPAREN, p17, 17'd1);
                  n_v = n_v + 2'd1;
               end
               slx_pkg::CLS_QUOTE: mode_in = slx_pkg::MODE_STRING;
               slx_pkg::CLS_MINUS: mode_in = slx_pkg::MODE_MINUS;
               slx_pkg::CLS_SPACE: mode_in = mode_in;
               slx_pkg::CLS_DIGIT: mode_in = slx_pkg::MODE_NUMBER;
               slx_pkg::CLS_ALPHA: mode_in = slx_pkg::MODE_IDENT;
               default: begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_BADCHAR, p17, 17'd1);
                  res_v[n_v[0]].last = 1'b1;
                  n_v = n_v + 2'd1;
                  failed  = 1'b1;
                  mode_in = slx_pkg::MODE_IDLE;
               end
            endcase
         end

         // close the open lexeme on the final byte
         if (item.eop && !failed) begin
            case (mode_in)
               slx_pkg::MODE_MINUS: begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_MINUS,
                                                       {1'b0, ls_in}, 17'd1);
                  n_v = n_v + 2'd1;
               end
               slx_pkg::MODE_NUMBER: begin
                  if (pp_in) begin
                     res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_INTEGER,
                                        {1'b0, ls_in}, slx_pkg::span({1'b0, ls_in}, p17));
                     n_v = n_v + 2'd1;
                     res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_BADCHAR, p17, 17'd1);
                     n_v = n_v + 2'd1;
                  end else begin
                     res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_INTEGER,
                                        {1'b0, ls_in}, slx_pkg::span({1'b0, ls_in}, end17));
                     n_v = n_v + 2'd1;
                  end
               end
               slx_pkg::MODE_DECIMAL: begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_DECIMAL,
                                     {1'b0, ls_in}, slx_pkg::span({1'b0, ls_in}, end17));
                  n_v = n_v + 2'd1;
               end
               slx_pkg::MODE_STRING: begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_UNTERM,
                                     {1'b0, ls_in}, slx_pkg::span({1'b0, ls_in}, end17));
                  n_v = n_v + 2'd1;
               end
               slx_pkg::MODE_IDENT: begin
                  res_v[n_v[0]] = slx_pkg::make_result(slx_pkg::KIND_IDENT,
                                     {1'b0, ls_in}, slx_pkg::span({1'b0, ls_in}, end17));
                  n_v = n_v + 2'd1;
               end
               default: begin
                  mode_in = slx_pkg::MODE_IDLE;
               end
            endcase
         end

         if (item.eop) begin
            if (n_v == 2'd2)      res_v[1].last = 1'b1;
            else if (n_v == 2'd1) res_v[0].last = 1'b1;
            mode_in = slx_pkg::MODE_IDLE;
            ls_in   = '0;
            pp_in   = 1'b0;
            err_in  = 1'b0;
         end else if (failed) begin
            err_in = 1'b1;
         end
      end
   end

   assign push_count = item_pop ? n_v : 2'd0;
   assign results[0] = res_v[0];
   assign results[1] = res_v[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= slx_pkg::MODE_IDLE;
         ls_ff   <= '0;
         pp_ff   <= 1'b0;
         err_ff  <= 1'b0;
      end else if (item_pop) begin
         mode_ff <= mode_in;
         ls_ff   <= ls_in;
         pp_ff   <= pp_in;
         err_ff  <= err_in;
      end
   end

endmodule
